### src/fac_pkg.sv
// Shared constants and types for the frustum box culling block.
`timescale 1ns / 1ps
`default_nettype none

package fac_pkg;

    // Number of frustum planes held in configuration registers.
    localparam int PLANE_COUNT = 6;
    // Width of the configuration register index.
    localparam int CFG_INDEX_W = 3;
    // Width of one packed plane register.
    localparam int PLANE_W = 64;
    // Width of one normal component and of the plane distance.
    localparam int NORMAL_W = 16;
    // Bit offsets of the fields inside a plane register.
    localparam int NX_LSB = 0;
    localparam int NY_LSB = 16;
    localparam int NZ_LSB = 32;
    localparam int DIST_LSB = 48;
    // Width of the pass-through box index.
    localparam int INDEX_W = 16;

    // Defaults for the top-level parameters.
    localparam int DEFAULT_COORD_WIDTH = 16;
    localparam int DEFAULT_NORMAL_FRAC_BITS = 14;

    // Advance enables for the three data stages of a plane lane.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } pipe_en_t;

endpackage

`default_nettype wire

### src/fac_plane_regs.sv
// Configuration registers holding the six packed frustum planes.
`timescale 1ns / 1ps
`default_nettype none

module fac_plane_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [fac_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [fac_pkg::PLANE_W-1:0]       cfg_data,
    output logic      [fac_pkg::PLANE_W-1:0]       plane [fac_pkg::PLANE_COUNT]
);

    logic [fac_pkg::PLANE_W-1:0] plane_reg [fac_pkg::PLANE_COUNT];

    // Writes to an index beyond the last plane are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fac_pkg::PLANE_COUNT; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_we && (32'(cfg_index) < fac_pkg::PLANE_COUNT))
        begin
            plane_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int i = 0; i < fac_pkg::PLANE_COUNT; i++)
        begin
            plane[i] = plane_reg[i];
        end
    end

endmodule

`default_nettype wire

### src/fac_plane_lane.sv
// Three-stage test of one box against one plane: products, axis sums, sign of the total.
`timescale 1ns / 1ps
`default_nettype none

module fac_plane_lane #(
    parameter int COORD_WIDTH      = fac_pkg::DEFAULT_COORD_WIDTH,
    parameter int NORMAL_FRAC_BITS = fac_pkg::DEFAULT_NORMAL_FRAC_BITS
) (
    input  wire logic                             clk,
    input  wire fac_pkg::pipe_en_t                en,
    input  wire logic signed [COORD_WIDTH-1:0]    center_x,
    input  wire logic signed [COORD_WIDTH-1:0]    center_y,
    input  wire logic signed [COORD_WIDTH-1:0]    center_z,
    input  wire logic        [COORD_WIDTH-2:0]    half_x,
    input  wire logic        [COORD_WIDTH-2:0]    half_y,
    input  wire logic        [COORD_WIDTH-2:0]    half_z,
    input  wire logic        [fac_pkg::PLANE_W-1:0] plane,
    output logic                                  outside
);

    // A coordinate times a Q1.14 normal fits exactly in PROD_W signed bits.
    localparam int PROD_W = COORD_WIDTH + fac_pkg::NORMAL_W;
    localparam int AX_W = PROD_W + 1;
    localparam int DIST_W = fac_pkg::NORMAL_W + NORMAL_FRAC_BITS + 1;
    localparam int SUM_W = ((AX_W + 2) > DIST_W ? (AX_W + 2) : DIST_W) + 1;

    logic signed [COORD_WIDTH-1:0]      c [3];
    logic        [COORD_WIDTH-2:0]      h [3];
    logic signed [fac_pkg::NORMAL_W-1:0] n [3];
    logic        [fac_pkg::NORMAL_W-1:0] an [3];

    logic signed [PROD_W-1:0] pc_reg [3];
    logic signed [PROD_W-1:0] pc_next [3];
    logic        [PROD_W-1:0] ph_reg [3];
    logic        [PROD_W-1:0] ph_next [3];
    logic signed [AX_W-1:0]   ax_reg [3];
    logic signed [AX_W-1:0]   ax_next [3];
    logic signed [SUM_W-1:0]  total;
    logic signed [fac_pkg::NORMAL_W-1:0] plane_dist;
    logic outside_reg;
    logic outside_next;

    always_comb
    begin
        c[0] = center_x;
        c[1] = center_y;
        c[2] = center_z;
        h[0] = half_x;
        h[1] = half_y;
        h[2] = half_z;
        n[0] = plane[fac_pkg::NX_LSB +: fac_pkg::NORMAL_W];
        n[1] = plane[fac_pkg::NY_LSB +: fac_pkg::NORMAL_W];
        n[2] = plane[fac_pkg::NZ_LSB +: fac_pkg::NORMAL_W];
        plane_dist = plane[fac_pkg::DIST_LSB +: fac_pkg::NORMAL_W];
        for (int a = 0; a < 3; a++)
        begin
            // The most negative component wraps to 0x8000, which is exactly 2.0 unsigned.
            an[a] = n[a][fac_pkg::NORMAL_W-1] ? (~n[a] + 1'b1) : n[a];
            pc_next[a] = PROD_W'(c[a]) * PROD_W'(n[a]);
            ph_next[a] = PROD_W'(h[a]) * PROD_W'(an[a]);
            ax_next[a] = AX_W'(pc_reg[a]) + AX_W'($signed(ph_reg[a]));
        end
        // sum < -distance is the same as sum + distance < 0, with the distance
        // on the normals' scale.
        total = SUM_W'(ax_reg[0]) + SUM_W'(ax_reg[1]) + SUM_W'(ax_reg[2])
              + (SUM_W'(plane_dist) <<< NORMAL_FRAC_BITS);
        outside_next = total[SUM_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            pc_reg <= pc_next;
            ph_reg <= ph_next;
        end
        if (en.s2)
        begin
            ax_reg <= ax_next;
        end
        if (en.s3)
        begin
            outside_reg <= outside_next;
        end
    end

    assign outside = outside_reg;

endmodule

`default_nettype wire

### src/frustum_aabb_cull.sv
// Top level of the frustum culling block for center/extents boxes.
//
// Usage: one box enters per transaction on the input channel (in_valid,
// in_stall) and one result leaves per transaction on the output channel
// (out_valid, out_stall). Each result carries the visible bit and the box
// index and last flag of its box, in input order.
// The six planes are written through cfg_we, cfg_index and cfg_data while
// the block is idle; a write to an index above five is ignored.
// From input transaction to result a box passes one stage of multipliers per
// plane, one stage of per-axis sums, one stage that adds the scaled distance
// and takes the sign, and the output register that merges the six plane
// verdicts. Throughput is one box per cycle while the receiver does not stall,
// set by the six parallel plane lanes, which each take a new box every cycle.
// Reset clears all planes to zero, which makes every box visible, and empties
// the pipeline. When the receiver stalls, the result holds in the output
// register and the stages behind it keep filling until every stage is full;
// only then is in_stall raised, so no transaction is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module frustum_aabb_cull #(
    parameter int COORD_WIDTH      = fac_pkg::DEFAULT_COORD_WIDTH,
    parameter int NORMAL_FRAC_BITS = fac_pkg::DEFAULT_NORMAL_FRAC_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [fac_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [fac_pkg::PLANE_W-1:0]       cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [COORD_WIDTH-1:0]     center_x,
    input  wire logic signed [COORD_WIDTH-1:0]     center_y,
    input  wire logic signed [COORD_WIDTH-1:0]     center_z,
    input  wire logic        [COORD_WIDTH-2:0]     half_x,
    input  wire logic        [COORD_WIDTH-2:0]     half_y,
    input  wire logic        [COORD_WIDTH-2:0]     half_z,
    input  wire logic        [fac_pkg::INDEX_W-1:0] box_index,
    input  wire logic                              last_box,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   visible,
    output logic             [fac_pkg::INDEX_W-1:0] result_index,
    output logic                                   result_last
);

    logic [fac_pkg::PLANE_W-1:0] plane [fac_pkg::PLANE_COUNT];
    logic [fac_pkg::PLANE_COUNT-1:0] outside;
    fac_pkg::pipe_en_t en;
    logic en_out;

    // Valid bits of the three lane stages and of the output register.
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic out_valid_reg;

    // Side-band fields that travel beside the lane data.
    logic [fac_pkg::INDEX_W-1:0] index_reg [3];
    logic                        last_reg [3];
    logic                        visible_reg;
    logic                        visible_next;
    logic [fac_pkg::INDEX_W-1:0] result_index_reg;
    logic                        result_last_reg;

    fac_plane_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .plane     (plane)
    );

    for (genvar p = 0; p < fac_pkg::PLANE_COUNT; p++)
    begin : g_lane
        fac_plane_lane #(
            .COORD_WIDTH      (COORD_WIDTH),
            .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
        ) u_lane (
            .clk      (clk),
            .en       (en),
            .center_x (center_x),
            .center_y (center_y),
            .center_z (center_z),
            .half_x   (half_x),
            .half_y   (half_y),
            .half_z   (half_z),
            .plane    (plane[p]),
            .outside  (outside[p])
        );
    end

    // A stage moves when it is empty or when the stage after it moves, so
    // bubbles collapse while the receiver stalls.
    always_comb
    begin
        en_out = !out_valid_reg || !out_stall;
        en.s3  = !v3_reg || en_out;
        en.s2  = !v2_reg || en.s3;
        en.s1  = !v1_reg || en.s2;
        in_stall = !en.s1;
        visible_next = ~|outside;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
            begin
                v1_reg <= in_valid;
            end
            if (en.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (en.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            index_reg[0] <= box_index;
            last_reg[0]  <= last_box;
        end
        if (en.s2)
        begin
            index_reg[1] <= index_reg[0];
            last_reg[1]  <= last_reg[0];
        end
        if (en.s3)
        begin
            index_reg[2] <= index_reg[1];
            last_reg[2]  <= last_reg[1];
        end
        if (en_out)
        begin
            visible_reg      <= visible_next;
            result_index_reg <= index_reg[2];
            result_last_reg  <= last_reg[2];
        end
    end

    assign out_valid    = out_valid_reg;
    assign visible      = visible_reg;
    assign result_index = result_index_reg;
    assign result_last  = result_last_reg;

    // An empty output register never blocks the input.
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled while output register empty");

    // An accepted transaction always lands in the first stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted transaction not held in first stage");

    // A blocked last stage keeps its item and its plane verdicts.
    a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !en.s3) |=> (v3_reg && $stable(outside) && $stable(index_reg[2])))
        else $error("blocked stage three changed");

    // The result shows the merged verdict of the item that moved out of stage three.
    a_visible_merge: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && en_out) |=> (out_valid_reg && (visible == ~|$past(outside))
            && (result_index == $past(index_reg[2]))))
        else $error("result does not match stage three");

endmodule

`default_nettype wire
